/* rtl/crc_pkg.sv */
// ----------------------------------------------------------------------------
// crc_pkg: shared constants and types for the convex ring checker
// Angle format, CORDIC arctangent table, turn accumulator widths and
// the result bundle of the CORDIC unit.
// ----------------------------------------------------------------------------
package crc_pkg;

    localparam int COORD_BITS_DEF   = 24;
    localparam int MAX_VERTICES_DEF = 4096;

    // binary angle units, one turn = 2**ANGLE_BITS
    localparam int ANGLE_BITS   = 16;
    localparam int FULL_TURN    = 65536;
    localparam int HALF_TURN    = 32768;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_BITS    = $clog2(CORDIC_ITERS);
    // coordinate difference is scaled by 2**SCALE_SHIFT before rotation
    localparam int SCALE_SHIFT  = 16;
    // guard bits for the scaled difference plus CORDIC gain
    localparam int CORDIC_GUARD = 20;

    // once the absolute sum passes SUM_LIMIT accumulation stops, so the
    // sums stay at or below SUM_LIMIT + HALF_TURN
    localparam int SUM_LIMIT = 65536 + 2047;
    localparam int SUM_BITS  = 18;

    localparam int TOL_BITS   = 11;
    localparam int TOL_RESET  = 2;
    localparam int COUNT_BITS = 13;
    localparam int COUNT_SAT  = 8191;

    localparam logic [ANGLE_BITS-1:0] ATAN_LUT [CORDIC_ITERS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0
    };

    typedef struct packed {
        logic                  done;
        logic [ANGLE_BITS-1:0] angle;
    } t_cordic_res;

endpackage

/* rtl/crc_cfg_if.sv */
// ----------------------------------------------------------------------------
// crc_cfg_if: configuration write channel
// Carries the turn tolerance register value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [crc_pkg::TOL_BITS-1:0]  turn_tolerance;

    modport source (output valid, output turn_tolerance, input ready);
    modport sink   (input valid, input turn_tolerance, output ready);
endinterface

/* rtl/crc_vertex_if.sv */
// ----------------------------------------------------------------------------
// crc_vertex_if: vertex input channel
// One item per vertex; last_vertex closes the ring.
// ----------------------------------------------------------------------------
interface crc_vertex_if #(
    parameter int COORD_BITS = crc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

/* rtl/crc_verdict_if.sv */
// ----------------------------------------------------------------------------
// crc_verdict_if: verdict output channel
// One item per ring: convexity flag and distinct vertex count.
// ----------------------------------------------------------------------------
interface crc_verdict_if;
    logic                           valid;
    logic                           ready;
    logic                           is_convex;
    logic [crc_pkg::COUNT_BITS-1:0] distinct_count;

    modport source (output valid, output is_convex, output distinct_count, input ready);
    modport sink   (input valid, input is_convex, input distinct_count, output ready);
endinterface

/* rtl/convex_ring_check.sv */
// ----------------------------------------------------------------------------
// convex_ring_check: streaming convexity test of one polygon ring
// Vertices arrive one item at a time; the last one yields the verdict.
// ----------------------------------------------------------------------------
// Usage
//   i_vertex : one item per vertex (x, y, last_vertex). The final vertex of
//              a ring carries last_vertex; if it equals the first it is dropped.
//   o_verdict: one item per ring, is_convex and distinct_count.
//   i_cfg    : turn_tolerance write, always ready; write only while idle.
// Timing
//   A vertex that needs an edge angle passes, from acceptance to the next
//   acceptance, through load, 16 CORDIC iterations, hand-off, turn update and
//   commit. A repeated or first vertex passes through commit only. The last
//   vertex adds the closing edge (another CORDIC pass) and two turn updates
//   unless the ring is short or has failed; its verdict is registered in S_OUT
//   once the output register is free, and i_vertex.ready returns in that same cycle.
//   The CORDIC unit is shared by the edge and closing-edge angles, so the
//   block works on one vertex at a time.
// Reset and stall
//   Reset empties the ring, clears a pending verdict and sets the tolerance
//   to 2. A verdict waits in the output register while o_verdict.ready is
//   low; new vertices are still taken, but the next verdict waits for it.
// ----------------------------------------------------------------------------
module convex_ring_check #(
    parameter int COORD_BITS   = crc_pkg::COORD_BITS_DEF,
    parameter int MAX_VERTICES = crc_pkg::MAX_VERTICES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    crc_cfg_if.sink        i_cfg,
    crc_vertex_if.sink     i_vertex,
    crc_verdict_if.source  o_verdict
);
    localparam int CNT_W    = $clog2(MAX_VERTICES + 2);
    localparam int SHOW_MAX = (MAX_VERTICES < crc_pkg::COUNT_SAT) ?
                              MAX_VERTICES : crc_pkg::COUNT_SAT;
    localparam int DW       = COORD_BITS + 1;
    localparam int AB       = crc_pkg::ANGLE_BITS;
    localparam int SB       = crc_pkg::SUM_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_TURN, S_COMMIT, S_FINAL, S_CLOSE, S_CT1, S_CT2, S_OUT
    } t_state;

    t_state                         r_state;
    logic signed [COORD_BITS-1:0]   r_first_x, r_first_y, r_prev_x, r_prev_y, r_x, r_y;
    logic                           r_last;
    logic [AB-1:0]                  r_first_edge, r_prev_edge;
    logic signed [SB-1:0]           r_ssum;
    logic [SB-1:0]                  r_asum;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_fail;
    logic [crc_pkg::TOL_BITS-1:0]   r_tol;
    logic                           r_out_valid, r_out_convex;
    logic [crc_pkg::COUNT_BITS-1:0] r_out_count;

    logic                           accept, take, cnt_zero, short_ring;
    logic                           in_eq_first, in_eq_prev, first_eq_prev;
    logic signed [COORD_BITS-1:0]   op_x, op_y;
    logic signed [DW-1:0]           dx, dy;
    logic                           cordic_start;
    crc_pkg::t_cordic_res           cres;

    logic [AB-1:0]                  turn_from, turn_to, d;
    logic                           d_pos, turn_en, turn_fail;
    logic signed [SB-1:0]           t, ns;
    logic [SB-1:0]                  mag, na, abs_ns;

    logic [CNT_W-1:0]               cnt_inc;
    logic                           overflow;
    logic signed [SB:0]             dev;
    logic [SB:0]                    abs_dev;
    logic                           convex_ok, out_free, out_load;
    logic [crc_pkg::COUNT_BITS-1:0] shown;

    // ---------------- handshake and compares ----------------
    assign i_cfg.ready    = 1'b1;
    assign i_vertex.ready = (r_state == S_IDLE);
    assign accept         = i_vertex.valid && (r_state == S_IDLE);

    assign in_eq_first   = (i_vertex.vertex_x == r_first_x) && (i_vertex.vertex_y == r_first_y);
    assign in_eq_prev    = (i_vertex.vertex_x == r_prev_x) && (i_vertex.vertex_y == r_prev_y);
    assign first_eq_prev = (r_first_x == r_prev_x) && (r_first_y == r_prev_y);
    assign cnt_zero      = (r_cnt == '0);
    assign short_ring    = (32'(r_cnt) <= 3);
    // a closing vertex equal to the first is dropped
    assign take          = !i_vertex.last_vertex || (!cnt_zero && !in_eq_first);

    // ---------------- CORDIC operands ----------------
    assign op_x = (r_state == S_IDLE) ? i_vertex.vertex_x : r_first_x;
    assign op_y = (r_state == S_IDLE) ? i_vertex.vertex_y : r_first_y;
    assign dx   = DW'(op_x) - DW'(r_prev_x);
    assign dy   = DW'(op_y) - DW'(r_prev_y);

    assign cordic_start = (accept && take && !cnt_zero && !in_eq_prev && !r_fail) ||
                          ((r_state == S_FINAL) && !short_ring && !r_fail && !first_eq_prev);

    crc_cordic #(
        .COORD_BITS (COORD_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_res   (cres)
    );

    // ---------------- turn accumulation ----------------
    always_comb begin
        turn_from = (r_state == S_CT2) ? cres.angle : r_prev_edge;
        turn_to   = (r_state == S_CT2) ? r_first_edge : cres.angle;
        d         = turn_to - turn_from;
        // exact half turn counts as positive
        d_pos  = (32'(d) <= crc_pkg::HALF_TURN);
        t      = d_pos ? signed'(SB'(d)) : signed'(SB'(d) - SB'(crc_pkg::FULL_TURN));
        mag    = d_pos ? SB'(d) : SB'(crc_pkg::FULL_TURN) - SB'(d);
        ns     = r_ssum + t;
        na     = r_asum + mag;
        abs_ns = (ns < 0) ? SB'(-ns) : SB'(ns);
        // mixed turn signs show up as |signed sum| falling below the absolute sum
        turn_fail = (abs_ns != na) || (32'(na) > crc_pkg::SUM_LIMIT);
        turn_en   = ((r_state == S_TURN) && (r_cnt != CNT_W'(1))) ||
                    (r_state == S_CT1) || (r_state == S_CT2);
    end

    // ---------------- counter and verdict ----------------
    always_comb begin
        cnt_inc  = (32'(r_cnt) <= MAX_VERTICES) ? r_cnt + 1'b1 : r_cnt;
        overflow = (32'(cnt_inc) > MAX_VERTICES);
        dev      = signed'({1'b0, r_asum}) - (SB + 1)'(crc_pkg::FULL_TURN);
        abs_dev  = (dev < 0) ? (SB + 1)'(-dev) : (SB + 1)'(dev);
        convex_ok = short_ring || (!r_fail && (abs_dev <= (SB + 1)'(r_tol)));
        shown    = (32'(r_cnt) > SHOW_MAX) ? crc_pkg::COUNT_BITS'(SHOW_MAX)
                                           : crc_pkg::COUNT_BITS'(r_cnt);
        out_free = !r_out_valid || o_verdict.ready;
        out_load = (r_state == S_OUT) && out_free;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fail      <= 1'b0;
            r_ssum      <= '0;
            r_asum      <= '0;
            r_out_valid <= 1'b0;
            r_tol       <= crc_pkg::TOL_BITS'(crc_pkg::TOL_RESET);
        end else begin
            if (i_cfg.valid) begin
                r_tol <= i_cfg.turn_tolerance;
            end
            if (o_verdict.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (turn_en && !r_fail) begin
                r_ssum <= ns;
                r_asum <= na;
                if (turn_fail) begin
                    r_fail <= 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x    <= i_vertex.vertex_x;
                        r_y    <= i_vertex.vertex_y;
                        r_last <= i_vertex.last_vertex;
                        if (!take) begin
                            r_state <= S_FINAL;
                        end else if (cnt_zero) begin
                            r_first_x <= i_vertex.vertex_x;
                            r_first_y <= i_vertex.vertex_y;
                            r_state   <= S_COMMIT;
                        end else if (in_eq_prev) begin
                            r_fail  <= 1'b1;
                            r_state <= S_COMMIT;
                        end else if (!r_fail) begin
                            r_state <= S_EDGE;
                        end else begin
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_EDGE: begin
                    if (cres.done) begin
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_first_edge <= cres.angle;
                    end
                    r_prev_edge <= cres.angle;
                    r_state     <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                    r_cnt    <= cnt_inc;
                    if (overflow) begin
                        r_fail <= 1'b1;
                    end
                    r_state <= r_last ? S_FINAL : S_IDLE;
                end
                S_FINAL: begin
                    if (!short_ring && !r_fail) begin
                        if (first_eq_prev) begin
                            r_fail  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CLOSE;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CLOSE: begin
                    if (cres.done) begin
                        r_state <= S_CT1;
                    end
                end
                S_CT1: begin
                    r_state <= S_CT2;
                end
                S_CT2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_convex <= convex_ok;
                        r_out_count  <= shown;
                        r_cnt        <= '0;
                        r_fail       <= 1'b0;
                        r_ssum       <= '0;
                        r_asum       <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_verdict.valid          = r_out_valid;
    assign o_verdict.is_convex      = r_out_convex;
    assign o_verdict.distinct_count = r_out_count;

endmodule

/* rtl/crc_cordic.sv */
// ----------------------------------------------------------------------------
// crc_cordic: iterative CORDIC atan2
// Vectoring mode, one shift-add iteration per cycle, angle in binary units.
// ----------------------------------------------------------------------------
module crc_cordic #(
    parameter int COORD_BITS = crc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS:0]   i_dx,
    input  logic signed [COORD_BITS:0]   i_dy,
    output crc_pkg::t_cordic_res         o_res
);
    localparam int W  = COORD_BITS + crc_pkg::CORDIC_GUARD;
    localparam int AB = crc_pkg::ANGLE_BITS;

    logic signed [W-1:0]             r_x, r_y, n_x, n_y;
    logic signed [W-1:0]             x0, y0, xs, ys;
    logic [AB-1:0]                   r_ang, n_ang;
    logic [crc_pkg::ITER_BITS-1:0]   r_iter;
    logic                            r_busy, r_done;

    always_comb begin
        x0 = W'(i_dx) <<< crc_pkg::SCALE_SHIFT;
        y0 = W'(i_dy) <<< crc_pkg::SCALE_SHIFT;
        // arithmetic shift floors, as required
        xs = r_x >>> r_iter;
        ys = r_y >>> r_iter;
        if (r_y >= 0) begin
            n_x   = r_x + ys;
            n_y   = r_y - xs;
            n_ang = r_ang + crc_pkg::ATAN_LUT[r_iter];
        end else begin
            n_x   = r_x - ys;
            n_y   = r_y + xs;
            n_ang = r_ang - crc_pkg::ATAN_LUT[r_iter];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                // fold the left half-plane onto the right
                if (x0 < 0) begin
                    r_x   <= -x0;
                    r_y   <= -y0;
                    r_ang <= AB'(crc_pkg::HALF_TURN);
                end else begin
                    r_x   <= x0;
                    r_y   <= y0;
                    r_ang <= '0;
                end
            end else if (r_busy) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_ang  <= n_ang;
                r_iter <= r_iter + 1'b1;
                if (r_iter == crc_pkg::ITER_BITS'(crc_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.angle = r_ang;

endmodule

/* rtl/crc_checker.sv */
// ----------------------------------------------------------------------------
// crc_checker: port-level checks for convex_ring_check
// Watches the vertex and verdict channels; bound to the top level below.
// ----------------------------------------------------------------------------
module crc_checker #(
    parameter int MAX_VERTICES = crc_pkg::MAX_VERTICES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_vtx_valid,
    input logic                           i_vtx_ready,
    input logic                           i_vtx_last,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_convex,
    input logic [crc_pkg::COUNT_BITS-1:0] i_out_count
);
    localparam int SHOW_MAX = (MAX_VERTICES < crc_pkg::COUNT_SAT) ?
                              MAX_VERTICES : crc_pkg::COUNT_SAT;

    // an accepted vertex makes the vertex channel drop ready
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vtx_valid && i_vtx_ready) |=> !i_vtx_ready)
        else $error("vertex channel ready straight after an item");

    // a vertex that does not close the ring never produces a verdict
    a_no_verdict_mid_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vtx_valid && i_vtx_ready && !i_vtx_last) |=> !$rose(i_out_valid))
        else $error("verdict raised by a non-final vertex");

    // stalled verdict holds
    a_verdict_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_convex) && $stable(i_out_count)))
        else $error("verdict changed while stalled");

    // rings of three or fewer vertices are always convex
    a_small_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_count <= crc_pkg::COUNT_BITS'(3))) |-> i_out_convex)
        else $error("small ring reported not convex");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_count) <= SHOW_MAX))
        else $error("distinct count above saturation limit");

endmodule

bind convex_ring_check crc_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_crc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_vtx_valid  (i_vertex.valid),
    .i_vtx_ready  (i_vertex.ready),
    .i_vtx_last   (i_vertex.last_vertex),
    .i_out_valid  (o_verdict.valid),
    .i_out_ready  (o_verdict.ready),
    .i_out_convex (o_verdict.is_convex),
    .i_out_count  (o_verdict.distinct_count)
);

/* tb/ring_verdict_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_verdict_check: convexity verdict checker
// Watches the configuration, vertex and verdict channels, runs its own
// turning-angle model of each ring and compares every verdict item with the
// oldest predicted one. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module ring_verdict_check #(
    parameter int MAX_VERTICES = crc_pkg::MAX_VERTICES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crc_cfg_if     i_cfg,
    crc_vertex_if  i_vertex,
    crc_verdict_if i_verdict,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        logic                           is_convex;
        logic [crc_pkg::COUNT_BITS-1:0] distinct_count;
    } t_verdict;

    t_verdict                       expected_verdicts[$];
    logic [crc_pkg::TOL_BITS-1:0]   tolerance;
    longint                         ring_x0, ring_y0, prev_x, prev_y;
    logic [crc_pkg::ANGLE_BITS-1:0] edge_ang0, prev_ang;
    longint                         turn_sum, turn_abs_sum;
    int                             kept_count;
    bit                             ring_broken;
    int                             fails = 0;

    // edge direction in binary angle units, shift-add rotation towards the x axis
    function automatic logic [crc_pkg::ANGLE_BITS-1:0] edge_angle(longint dx, longint dy);
        longint      x, y, xs, ys;
        logic [31:0] ang;
        x   = dx <<< crc_pkg::SCALE_SHIFT;
        y   = dy <<< crc_pkg::SCALE_SHIFT;
        ang = 0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = crc_pkg::HALF_TURN;
        end
        for (int i = 0; i < crc_pkg::CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x   += ys;
                y   -= xs;
                ang += crc_pkg::ATAN_LUT[i];
            end else begin
                x   -= ys;
                y   += xs;
                ang -= crc_pkg::ATAN_LUT[i];
            end
        end
        return ang[crc_pkg::ANGLE_BITS-1:0];
    endfunction

    function automatic void add_turn(logic [crc_pkg::ANGLE_BITS-1:0] from_ang,
                                     logic [crc_pkg::ANGLE_BITS-1:0] to_ang);
        logic [crc_pkg::ANGLE_BITS-1:0] d;
        longint                         t, s;
        d = to_ang - from_ang;
        // an exact half turn counts as positive
        t = (d <= crc_pkg::HALF_TURN) ? longint'(d) : longint'(d) - crc_pkg::FULL_TURN;
        if (ring_broken)
            return;
        turn_sum     += t;
        turn_abs_sum += (t < 0) ? -t : t;
        s = (turn_sum < 0) ? -turn_sum : turn_sum;
        if (s != turn_abs_sum || turn_abs_sum > crc_pkg::SUM_LIMIT)
            ring_broken = 1'b1;
    endfunction

    function automatic void take_vertex(longint x, longint y);
        logic [crc_pkg::ANGLE_BITS-1:0] a;
        if (kept_count == 0) begin
            ring_x0 = x;
            ring_y0 = y;
        end else if (x == prev_x && y == prev_y) begin
            ring_broken = 1'b1;
        end else if (!ring_broken) begin
            a = edge_angle(x - prev_x, y - prev_y);
            if (kept_count == 1)
                edge_ang0 = a;
            else
                add_turn(prev_ang, a);
            prev_ang = a;
        end
        prev_x = x;
        prev_y = y;
        if (kept_count <= MAX_VERTICES)
            kept_count++;
        if (kept_count > MAX_VERTICES)
            ring_broken = 1'b1;
    endfunction

    function automatic void clear_ring();
        ring_x0      = 0;
        ring_y0      = 0;
        prev_x       = 0;
        prev_y       = 0;
        edge_ang0    = '0;
        prev_ang     = '0;
        turn_sum     = 0;
        turn_abs_sum = 0;
        kept_count   = 0;
        ring_broken  = 1'b0;
    endfunction

    function automatic void predict_item(longint x, longint y, bit last);
        logic [crc_pkg::ANGLE_BITS-1:0] a;
        longint                         dev;
        int                             shown;
        t_verdict                       v;
        if (!last) begin
            take_vertex(x, y);
            return;
        end
        // a closing vertex equal to the first is dropped
        if (kept_count != 0 && !(x == ring_x0 && y == ring_y0))
            take_vertex(x, y);
        if (kept_count <= 3) begin
            v.is_convex = 1'b1;
        end else begin
            if (!ring_broken) begin
                if (ring_x0 == prev_x && ring_y0 == prev_y) begin
                    ring_broken = 1'b1;
                end else begin
                    a = edge_angle(ring_x0 - prev_x, ring_y0 - prev_y);
                    add_turn(prev_ang, a);
                    add_turn(a, edge_ang0);
                end
            end
            if (ring_broken) begin
                v.is_convex = 1'b0;
            end else begin
                dev = turn_abs_sum - crc_pkg::FULL_TURN;
                if (dev < 0)
                    dev = -dev;
                v.is_convex = (dev <= longint'(tolerance));
            end
        end
        shown = (kept_count > MAX_VERTICES) ? MAX_VERTICES : kept_count;
        if (shown > crc_pkg::COUNT_SAT)
            shown = crc_pkg::COUNT_SAT;
        v.distinct_count = shown[crc_pkg::COUNT_BITS-1:0];
        expected_verdicts.insert(expected_verdicts.size(), v);
        clear_ring();
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            tolerance = crc_pkg::TOL_RESET;
            clear_ring();
            expected_verdicts.delete();
        end else begin
            if (i_verdict.valid && i_verdict.ready) begin
                if (expected_verdicts.size() == 0) begin
                    fails++;
                    $display("%0t: verdict item with none expected: convex=%0d count=%0d",
                             $time, i_verdict.is_convex, i_verdict.distinct_count);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_verdict.is_convex !== want.is_convex ||
                        i_verdict.distinct_count !== want.distinct_count) begin
                        fails++;
                        $display("%0t: verdict mismatch: expected convex=%0d count=%0d, %s",
                                 $time, want.is_convex, want.distinct_count,
                                 $sformatf("got convex=%0d count=%0d",
                                           i_verdict.is_convex,
                                           i_verdict.distinct_count));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                tolerance = i_cfg.turn_tolerance;
            if (i_vertex.valid && i_vertex.ready)
                predict_item(longint'(i_vertex.vertex_x), longint'(i_vertex.vertex_y),
                             i_vertex.last_vertex);
        end
        o_pending    <= expected_verdicts.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: convex ring checker testbench
// Drives directed rings and random rings (mostly convex polygons, some
// dented or with repeats, some noise) under several tolerance settings and
// idle/stall phases. Checking is done by ring_verdict_check.
// ----------------------------------------------------------------------------
module tb;

    localparam int  COORD_MAX = 8388607;
    localparam int  COORD_MIN = -8388608;
    localparam real TWO_PI    = 6.283185307179586;

    logic clk;
    logic rst_n;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   fail_count;
    int   pending;
    int   ring_xs[$];
    int   ring_ys[$];
    int   extremes[4] = '{COORD_MIN, COORD_MAX, 0, -1};

    crc_cfg_if                                            cfg_bus();
    crc_vertex_if #(.COORD_BITS(crc_pkg::COORD_BITS_DEF)) vertex_bus();
    crc_verdict_if                                        verdict_bus();

    convex_ring_check i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_bus),
        .i_vertex  (vertex_bus),
        .o_verdict (verdict_bus)
    );

    ring_verdict_check i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_bus),
        .i_vertex     (vertex_bus),
        .i_verdict    (verdict_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            verdict_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #6000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_vertex(input int x, input int y, input bit last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            vertex_bus.valid <= 1'b0;
            @(negedge clk);
        end
        vertex_bus.valid       <= 1'b1;
        vertex_bus.vertex_x    <= x[crc_pkg::COORD_BITS_DEF-1:0];
        vertex_bus.vertex_y    <= y[crc_pkg::COORD_BITS_DEF-1:0];
        vertex_bus.last_vertex <= last;
        do @(posedge clk); while (!vertex_bus.ready);
    endtask

    task automatic send_ring();
        for (int i = 0; i < ring_xs.size(); i++)
            send_vertex(ring_xs[i], ring_ys[i], i == ring_xs.size() - 1);
    endtask

    task automatic add_point(input int x, input int y);
        ring_xs.insert(ring_xs.size(), x);
        ring_ys.insert(ring_ys.size(), y);
    endtask

    // n points on a circle in angular order; jitter spreads them unevenly
    task automatic make_convex(input int n, input bit cw, input int r, input real jitter,
                               input bit close_dup);
        real theta, base;
        int  lim, cx, cy;
        ring_xs.delete();
        ring_ys.delete();
        lim  = COORD_MAX - r - 1;
        cx   = int'($urandom_range(2 * lim)) - lim;
        cy   = int'($urandom_range(2 * lim)) - lim;
        base = $urandom_range(999) / 1000.0 * TWO_PI;
        for (int k = 0; k < n; k++) begin
            theta = base + TWO_PI * (k + jitter * $urandom_range(999) / 1000.0) / n;
            if (cw)
                theta = -theta;
            add_point(cx + $rtoi(r * $cos(theta)), cy + $rtoi(r * $sin(theta)));
        end
        if (close_dup)
            add_point(ring_xs[0], ring_ys[0]);
    endtask

    // idle first: the last vertex item must not be offered again
    task automatic write_tolerance(input int value);
        @(negedge clk);
        vertex_bus.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.turn_tolerance <= value[crc_pkg::TOL_BITS-1:0];
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int sent, kind, n, r, i, j, mode, tmp;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(99);
            case ($urandom_range(2))
                0:       r = $urandom_range(20, 1);
                1:       r = $urandom_range(5000, 21);
                default: r = $urandom_range(4000000, 5001);
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(48, 11) : $urandom_range(10, 3);
            if (kind < 60) begin
                make_convex(n, $urandom_range(1), r, 0.8, $urandom_range(1));
            end else if (kind < 80) begin
                make_convex(n, $urandom_range(1), r, 0.8, 1'b0);
                i = $urandom_range(ring_xs.size() - 1);
                j = $urandom_range(ring_xs.size() - 1);
                case ($urandom_range(3))
                    0: begin
                        ring_xs.insert(i, ring_xs[i]);
                        ring_ys.insert(i, ring_ys[i]);
                    end
                    1: begin
                        tmp = ring_xs[i]; ring_xs[i] = ring_xs[j]; ring_xs[j] = tmp;
                        tmp = ring_ys[i]; ring_ys[i] = ring_ys[j]; ring_ys[j] = tmp;
                    end
                    2: begin
                        // dent inwards
                        ring_xs[i] = (ring_xs[i] + ring_xs[j]) / 2;
                        ring_ys[i] = (ring_ys[i] + ring_ys[j]) / 2;
                    end
                    default: begin
                        // ring walks back through its start and on
                        add_point(ring_xs[0], ring_ys[0]);
                        add_point(ring_xs[i], ring_ys[i]);
                    end
                endcase
            end else begin
                ring_xs.delete();
                ring_ys.delete();
                n    = $urandom_range(9, 1);
                mode = $urandom_range(2);
                for (int k = 0; k < n; k++) begin
                    case (mode)
                        0:       add_point(int'($urandom) >>> 8, int'($urandom) >>> 8);
                        1:       add_point($urandom_range(3), $urandom_range(3));
                        default: add_point(extremes[$urandom_range(3)],
                                           extremes[$urandom_range(3)]);
                    endcase
                end
            end
            send_ring();
            sent += ring_xs.size();
        end
    endtask

    initial begin
        rst_n                  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.turn_tolerance = '0;
        vertex_bus.valid       = 1'b0;
        vertex_bus.vertex_x    = '0;
        vertex_bus.vertex_y    = '0;
        vertex_bus.last_vertex = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single vertex: taken as the closing duplicate
        send_vertex(5, 5, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        // small ring with a repeat: still reported convex
        send_vertex(1, 1, 1'b0);
        send_vertex(1, 1, 1'b0);
        send_vertex(2, 3, 1'b1);
        // full-range square with closing duplicate
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        // exact half turn on a backtrack
        send_vertex(0, 0, 1'b0);
        send_vertex(10, 0, 1'b0);
        send_vertex(-10, 0, 1'b0);
        send_vertex(0, 5, 1'b1);
        // repeat across the wrap
        send_vertex(0, 0, 1'b0);
        send_vertex(10, 0, 1'b0);
        send_vertex(10, 10, 1'b0);
        send_vertex(0, 0, 1'b0);
        send_vertex(0, 0, 1'b1);
        // consecutive repeat
        send_vertex(0, 0, 1'b0);
        send_vertex(8, 0, 1'b0);
        send_vertex(8, 0, 1'b0);
        send_vertex(8, 8, 1'b0);
        send_vertex(0, 8, 1'b1);

        write_tolerance(0);
        run_random(480);
        write_tolerance(2047);
        idle_pct = 46;
        run_random(480);
        write_tolerance(1024);
        idle_pct  = 0;
        stall_pct = 46;
        run_random(480);
        write_tolerance($urandom_range(2047));
        idle_pct  = 13;
        stall_pct = 13;
        run_random(480);

        @(negedge clk);
        vertex_bus.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
